// File: sv/mips_integer_subset_executor_defines.svh
// Assertion macros used by the checker file of the executor.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MIPS_INTEGER_SUBSET_EXECUTOR_DEFINES_SVH
`define MIPS_INTEGER_SUBSET_EXECUTOR_DEFINES_SVH

// same-cycle implication, held off while in reset
`define MISE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, held off while in reset
`define MISE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: sv/mise_pkg.sv
// Shared types, constants and helpers of the MIPS integer subset executor.
// No dependencies; used by all RTL and checker files.
`default_nettype none

package mise_pkg;

  localparam int MEM_WORDS = 256;
  localparam int PC_BITS   = 16;
  localparam int DM_AW     = $clog2(MEM_WORDS);
  localparam int NUM_REGS  = 32;
  localparam int RF_AW     = 5;
  localparam int PLEN_W    = 15;

  localparam logic [2:0] REQ_EXEC   = 3'd0;
  localparam logic [2:0] REQ_WR_REG = 3'd1;
  localparam logic [2:0] REQ_WR_MEM = 3'd2;
  localparam logic [2:0] REQ_RD_REG = 3'd3;
  localparam logic [2:0] REQ_RD_MEM = 3'd4;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_SLT = 6'd42;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ADDR  = 2'd1;
  localparam logic [1:0] ST_BAD_INSTR = 2'd2;

  localparam logic [4:0] STG_IF  = 5'b00001;
  localparam logic [4:0] STG_ID  = 5'b00010;
  localparam logic [4:0] STG_EX  = 5'b00100;
  localparam logic [4:0] STG_MEM = 5'b01000;
  localparam logic [4:0] STG_WB  = 5'b10000;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [31:0]        instr_word;
    logic [7:0]         target_index;
    logic signed [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_data;
    logic signed [15:0] next_pc;
    logic               halted;
    logic [4:0]         stage_mask;
    logic [2:0]         stage_count;
    logic [31:0]        cycle_total;
    logic [31:0]        instr_number;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [RF_AW-1:0] waddr;
    logic [31:0]      wdata;
    logic             re;
    logic [RF_AW-1:0] raddr_a;
    logic [RF_AW-1:0] raddr_b;
  } rf_ctl_t;

  typedef struct packed {
    logic             we;
    logic [DM_AW-1:0] waddr;
    logic [31:0]      wdata;
    logic             re;
    logic [DM_AW-1:0] raddr;
  } dm_ctl_t;

  function automatic logic [2:0] stage_cnt(input logic [4:0] m);
    logic [2:0] c;
    c = '0;
    for (int i = 0; i < 5; i++) c = c + {2'b00, m[i]};
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/mise_regfile.sv
// 32-entry register file, one write port, two registered read ports.
// Per-entry valid bits give the all-zero reset. Depends on mise_pkg.
`default_nettype none

module mise_regfile (
  input  logic              clk,
  input  logic              rst_n,
  input  mise_pkg::rf_ctl_t ctl,
  output logic [31:0]       rdata_a,
  output logic [31:0]       rdata_b
);
  import mise_pkg::*;

  logic [31:0]         rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [31:0]         rd_a_r, rd_b_r;
  logic                vld_a_r, vld_b_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      rf_mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rd_a_r <= rf_mem[ctl.raddr_a];
      rd_b_r <= rf_mem[ctl.raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (ctl.we) begin
        vld_r[ctl.waddr] <= 1'b1;
      end
      if (ctl.re) begin
        vld_a_r <= vld_r[ctl.raddr_a];
        vld_b_r <= vld_r[ctl.raddr_b];
      end
    end
  end

  assign rdata_a = vld_a_r ? rd_a_r : '0;
  assign rdata_b = vld_b_r ? rd_b_r : '0;

endmodule

`default_nettype wire

// File: sv/mise_dmem.sv
// Word data memory, one write port, one registered read port.
// Per-word valid bits give the all-zero reset. Depends on mise_pkg.
`default_nettype none

module mise_dmem (
  input  logic              clk,
  input  logic              rst_n,
  input  mise_pkg::dm_ctl_t ctl,
  output logic [31:0]       rdata
);
  import mise_pkg::*;

  logic [31:0]          dm_mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_r;
  logic [31:0]          rd_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      dm_mem[ctl.waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rd_r <= dm_mem[ctl.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.we) begin
        vld_r[ctl.waddr] <= 1'b1;
      end
      if (ctl.re) begin
        rd_vld_r <= vld_r[ctl.raddr];
      end
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

`default_nettype wire

// File: sv/mips_integer_subset_executor.sv
// Top level of the MIPS integer subset executor: sequencer, pc and counters.
// Depends on mise_pkg, mise_regfile and mise_dmem.
//
//   channel | ports                        | direction | carries
//   in      | in_valid in_ready in_item    | input     | request item
//   out     | out_valid out_ready out_item | output    | result item
//   cfg     | cfg_valid cfg_ready cfg_data | input     | program_length
//
// Each item passes through accept (S_IDLE) and execute (S_EXE); an in-range lw also
// passes through S_MEM, the data memory read at the address formed from the register
// read. Register file and data memory reads are synchronous (registered).
// A result waits in the output register; the next item is accepted meanwhile
// and finishes once that register is free. Reset is synchronous, active low.
`default_nettype none

module mips_integer_subset_executor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mise_pkg::in_item_t             in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mise_pkg::out_item_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mise_pkg::PLEN_W-1:0]    cfg_data
);
  import mise_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXE  = 3'b010,
    S_MEM  = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  in_item_t            req_r;
  logic [PC_BITS-1:0]  pc_r, pc_nxt;
  logic [31:0]         cyc_r, cyc_nxt;
  logic [31:0]         icnt_r, icnt_nxt;
  logic [PLEN_W-1:0]   plen_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  rf_ctl_t             rf_ctl;
  dm_ctl_t             dm_ctl;
  logic [31:0]         rf_a, rf_b, dm_rdata;

  logic                in_fire, out_free, fin, lw_ok, is_exec;
  logic [5:0]          op, fn;
  logic [4:0]          rt, rd;
  logic [15:0]         imm16;
  logic [31:0]         imm32;
  logic signed [31:0]  a_q;
  logic signed [15:0]  imm_q;
  logic signed [32:0]  idx;
  logic                idx_ok, tgt_mem_ok, tgt_reg_ok;
  logic [1:0]          status;
  logic [31:0]         rdata;
  logic [4:0]          mask;
  logic [2:0]          cnt;
  logic                rf_we_raw;
  logic [RF_AW-1:0]    rf_waddr;
  logic [31:0]         rf_wdata;
  logic                dm_we_raw;
  logic [DM_AW-1:0]    dm_waddr;
  logic [31:0]         dm_wdata;
  logic [31:0]         npc32;
  out_item_t           res;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign op    = req_r.instr_word[31:26];
  assign rt    = req_r.instr_word[20:16];
  assign rd    = req_r.instr_word[15:11];
  assign fn    = req_r.instr_word[5:0];
  assign imm16 = req_r.instr_word[15:0];
  assign imm32 = {{16{imm16[15]}}, imm16};
  assign is_exec = (req_r.req_type == REQ_EXEC);

  // quotients truncated toward zero
  assign a_q   = rf_a[31] ? ($signed(rf_a + 32'd3) >>> 2) : ($signed(rf_a) >>> 2);
  assign imm_q = imm16[15] ? ($signed(imm16 + 16'd3) >>> 2) : ($signed(imm16) >>> 2);
  assign idx   = {a_q[31], a_q} + {{17{imm_q[15]}}, imm_q};
  assign idx_ok = !idx[32] && (idx[31:0] < 32'(MEM_WORDS));

  assign tgt_mem_ok = ({24'b0, req_r.target_index} < 32'(MEM_WORDS));
  assign tgt_reg_ok = (req_r.target_index[7:5] == 3'b000);

  always_comb begin
    status    = ST_OK;
    rdata     = '0;
    mask      = '0;
    pc_nxt    = pc_r;
    lw_ok     = 1'b0;
    rf_we_raw = 1'b0;
    rf_waddr  = rd;
    rf_wdata  = '0;
    dm_we_raw = 1'b0;
    dm_waddr  = idx[DM_AW-1:0];
    dm_wdata  = rf_b;
    unique case (req_r.req_type)
      REQ_EXEC: begin
        pc_nxt = pc_r + PC_BITS'(1);
        unique case (op) inside
          OP_RTYPE: begin
            mask = STG_IF | STG_ID;
            unique case (fn)
              FN_ADD: begin
                rf_we_raw = 1'b1;
                rf_wdata  = rf_a + rf_b;
                mask      = mask | STG_EX | STG_WB;
              end
              FN_SUB: begin
                rf_we_raw = 1'b1;
                rf_wdata  = rf_a - rf_b;
                mask      = mask | STG_EX | STG_WB;
              end
              FN_SLT: begin
                rf_we_raw = 1'b1;
                rf_wdata  = {31'b0, ($signed(rf_a) < $signed(rf_b))};
                mask      = mask | STG_EX | STG_WB;
              end
              default: status = ST_BAD_INSTR;
            endcase
          end
          OP_BEQ, OP_BNE: begin
            if ((op == OP_BEQ) == (rf_a == rf_b)) begin
              pc_nxt = pc_r + PC_BITS'(1) + imm32[PC_BITS-1:0];
            end
            mask = STG_IF | STG_ID | STG_EX;
          end
          OP_ADDI: begin
            rf_we_raw = 1'b1;
            rf_waddr  = rt;
            rf_wdata  = rf_a + imm32;
            mask      = STG_IF | STG_ID | STG_EX | STG_WB;
          end
          OP_LW, OP_SW: begin
            mask = STG_IF | STG_ID | STG_EX | STG_MEM;
            if (!idx_ok) begin
              status = ST_BAD_ADDR;
            end else if (op == OP_LW) begin
              lw_ok = 1'b1;
            end else begin
              dm_we_raw = 1'b1;
            end
            if (op == OP_LW) begin
              mask = mask | STG_WB;
            end
          end
          default: status = ST_BAD_INSTR;
        endcase
      end
      REQ_WR_REG: begin
        rf_we_raw = tgt_reg_ok;
        rf_waddr  = req_r.target_index[RF_AW-1:0];
        rf_wdata  = req_r.write_value;
      end
      REQ_WR_MEM: begin
        dm_we_raw = tgt_mem_ok;
        dm_waddr  = req_r.target_index[DM_AW-1:0];
        dm_wdata  = req_r.write_value;
        if (!tgt_mem_ok) status = ST_BAD_ADDR;
      end
      REQ_RD_REG: begin
        rdata = tgt_reg_ok ? rf_a : '0;
      end
      REQ_RD_MEM: begin
        rdata = tgt_mem_ok ? dm_rdata : '0;
        if (!tgt_mem_ok) status = ST_BAD_ADDR;
      end
      default: ;
    endcase
    // lw write-back once the memory word has arrived
    if (state_r == S_MEM) begin
      rf_we_raw = 1'b1;
      rf_waddr  = rt;
      rf_wdata  = dm_rdata;
    end
  end

  assign cnt      = stage_cnt(mask);
  assign cyc_nxt  = is_exec ? (cyc_r + {29'b0, cnt}) : cyc_r;
  assign icnt_nxt = is_exec ? (icnt_r + 32'd1) : icnt_r;
  assign npc32    = 32'(signed'(pc_nxt));

  assign fin = out_free && (((state_r == S_EXE) && !lw_ok) || (state_r == S_MEM));

  always_comb begin
    res.status       = status;
    res.read_data    = rdata;
    res.next_pc      = npc32[15:0];
    res.halted       = npc32[31] || (npc32 >= {17'b0, plen_r});
    res.stage_mask   = mask;
    res.stage_count  = cnt;
    res.cycle_total  = cyc_nxt;
    res.instr_number = icnt_nxt;
  end

  always_comb begin
    rf_ctl.we      = fin && rf_we_raw && (rf_waddr != '0);
    rf_ctl.waddr   = rf_waddr;
    rf_ctl.wdata   = rf_wdata;
    rf_ctl.re      = in_fire;
    rf_ctl.raddr_a = (in_item.req_type == REQ_EXEC) ? in_item.instr_word[25:21]
                                                    : in_item.target_index[RF_AW-1:0];
    rf_ctl.raddr_b = in_item.instr_word[20:16];
    dm_ctl.we      = fin && dm_we_raw;
    dm_ctl.waddr   = dm_waddr;
    dm_ctl.wdata   = dm_wdata;
    dm_ctl.re      = in_fire || ((state_r == S_EXE) && lw_ok);
    dm_ctl.raddr   = in_fire ? in_item.target_index[DM_AW-1:0] : idx[DM_AW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_EXE;
      S_EXE: begin
        if (lw_ok) state_nxt = S_MEM;
        else if (out_free) state_nxt = S_IDLE;
      end
      S_MEM: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      cyc_r       <= '0;
      icnt_r      <= '0;
      plen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        plen_r <= cfg_data;
      end
      if (fin) begin
        pc_r        <= pc_nxt;
        cyc_r       <= cyc_nxt;
        icnt_r      <= icnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_item;
    end
    if (fin) begin
      out_item_r <= res;
    end
  end

  mise_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rf_ctl),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  mise_dmem u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (dm_ctl),
    .rdata (dm_rdata)
  );

endmodule

`default_nettype wire

// File: sv/mise_checker.sv
// Port-level checks of the executor, bound to the top level.
// Depends on mise_pkg and mips_integer_subset_executor_defines.svh.
`default_nettype none
`include "mips_integer_subset_executor_defines.svh"

module mise_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input mise_pkg::out_item_t out_item
);
  logic [2:0] mask_ones;

  assign mask_ones = 3'($countones(out_item.stage_mask));

  `MISE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))
  `MISE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `MISE_ASSERT_IMP(a_stage_count, clk, rst_n, out_valid, out_item.stage_count == mask_ones)
  `MISE_ASSERT_IMP(a_neg_pc_halts, clk, rst_n, out_valid && out_item.next_pc[15], out_item.halted)

endmodule

bind mips_integer_subset_executor mise_checker u_mise_checker (.*);

`default_nettype wire

// File: tb/sv/mips_integer_subset_executor_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for mips_integer_subset_executor: a directed table, then random
// requests over several program_length settings, checked against an in-bench predictor.
// Depends on mise_pkg and the executor RTL only.

module mips_integer_subset_executor_tb;
  import mise_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 280;

  localparam logic [2:0] REQ_UNKNOWN = 3'd7;

  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [PLEN_W-1:0]   cfg_data;

  // predictor state
  logic [31:0]       gpr [NUM_REGS];
  logic [31:0]       dmem [MEM_WORDS];
  logic [15:0]       pc;
  logic [31:0]       cycles_run;
  logic [31:0]       instrs_run;
  logic [PLEN_W-1:0] prog_len;

  dir_row_t  rows[$];
  out_item_t pending_results[$];
  int        mismatches;
  int        results_checked;
  int        requests_sent;
  int        settings_used;
  int        cycle_count;
  bit        tx_burst;
  bit        rx_burst;
  bit        hold_request;
  int        hold_left;
  int        rx_stall_left;

  mips_integer_subset_executor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("mips_integer_subset_executor regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [5:0] fn);
    return {OP_RTYPE, rs, rt, rd, 5'($urandom), fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic in_item_t make_req(logic [2:0] req, logic [31:0] word, logic [7:0] tgt,
                                        logic [31:0] val);
    in_item_t it;
    it.req_type     = req;
    it.instr_word   = word;
    it.target_index = tgt;
    it.write_value  = val;
    return it;
  endfunction

  task automatic add_row(in_item_t item, bit fixed, out_item_t want);
    dir_row_t row;
    row.item  = item;
    row.fixed = fixed;
    row.want  = want;
    rows = {rows, row};
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_gpr(logic [4:0] idx, logic [31:0] val);
    if (idx != 5'd0) gpr[idx] = val;
  endfunction

  // Applies one request to the predictor state and returns the result it causes.
  function automatic out_item_t execute_request(in_item_t it);
    out_item_t   r;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm32;
    logic [15:0] npc;
    logic [4:0]  used;
    logic [2:0]  cnt;
    int          base;
    int          offs;
    int          addr;
    r    = '0;
    used = '0;
    cnt  = '0;
    case (it.req_type)
      REQ_EXEC: begin
        op    = it.instr_word[31:26];
        rs    = it.instr_word[25:21];
        rt    = it.instr_word[20:16];
        rd    = it.instr_word[15:11];
        fn    = it.instr_word[5:0];
        a     = gpr[rs];
        b     = gpr[rt];
        imm32 = {{16{it.instr_word[15]}}, it.instr_word[15:0]};
        npc   = pc + 16'd1;
        instrs_run++;
        if (op == OP_RTYPE) begin
          used = STG_IF | STG_ID;
          if (fn == FN_ADD) begin
            put_gpr(rd, a + b);
            used |= STG_EX | STG_WB;
          end else if (fn == FN_SUB) begin
            put_gpr(rd, a - b);
            used |= STG_EX | STG_WB;
          end else if (fn == FN_SLT) begin
            put_gpr(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
            used |= STG_EX | STG_WB;
          end else begin
            r.status = ST_BAD_INSTR;
          end
        end else if (op == OP_BEQ || op == OP_BNE) begin
          if ((op == OP_BEQ) == (a == b)) npc = pc + 16'd1 + imm32[15:0];
          used = STG_IF | STG_ID | STG_EX;
        end else if (op == OP_ADDI) begin
          put_gpr(rt, a + imm32);
          used = STG_IF | STG_ID | STG_EX | STG_WB;
        end else if (op == OP_LW || op == OP_SW) begin
          base = $signed(a);
          offs = $signed(imm32);
          addr = base / 4 + offs / 4;
          if (addr < 0 || addr >= MEM_WORDS) r.status = ST_BAD_ADDR;
          else if (op == OP_LW) put_gpr(rt, dmem[addr]);
          else dmem[addr] = b;
          used = STG_IF | STG_ID | STG_EX | STG_MEM;
          if (op == OP_LW) used |= STG_WB;
        end else begin
          r.status = ST_BAD_INSTR;
        end
        cnt = 3'($countones(used));
        cycles_run += 32'(cnt);
        pc = npc;
      end
      REQ_WR_REG: if (it.target_index < NUM_REGS) put_gpr(it.target_index[4:0], it.write_value);
      REQ_WR_MEM: begin
        if (it.target_index < MEM_WORDS) dmem[it.target_index] = it.write_value;
        else r.status = ST_BAD_ADDR;
      end
      REQ_RD_REG: if (it.target_index < NUM_REGS) r.read_data = gpr[it.target_index[4:0]];
      REQ_RD_MEM: begin
        if (it.target_index < MEM_WORDS) r.read_data = dmem[it.target_index];
        else r.status = ST_BAD_ADDR;
      end
      default: ;
    endcase
    r.next_pc      = pc;
    r.halted       = pc[15] || (pc >= {1'b0, prog_len});
    r.stage_mask   = used;
    r.stage_count  = cnt;
    r.cycle_total  = cycles_run;
    r.instr_number = instrs_run;
    return r;
  endfunction

  function automatic in_item_t random_request();
    in_item_t    it;
    int          pick;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [15:0] imm;
    it.req_type     = REQ_EXEC;
    it.instr_word   = $urandom;
    it.target_index = 8'($urandom);
    it.write_value  = $urandom;
    rs   = 5'($urandom);
    rt   = 5'($urandom);
    rd   = 5'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 7))
        0: it.instr_word = rtype(rs, rt, rd, FN_ADD);
        1: it.instr_word = rtype(rs, rt, rd, FN_SUB);
        2: it.instr_word = rtype(rs, rt, rd, FN_SLT);
        3: it.instr_word = itype(OP_ADDI, rs, rt, 16'($urandom));
        4, 5: begin
          imm = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16) - 8);
          it.instr_word = itype(($urandom_range(0, 1) == 0) ? OP_BEQ : OP_BNE, rs, rt, imm);
        end
        default: begin
          imm = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1164) - 64);
          it.instr_word = itype(($urandom_range(0, 1) == 0) ? OP_LW : OP_SW, rs, rt, imm);
        end
      endcase
    end else if (pick < 65) begin
      // raw word: mostly unsupported opcodes and functs
    end else if (pick < 77) begin
      it.req_type = REQ_WR_REG;
      if ($urandom_range(0, 5) != 0) it.target_index = 8'($urandom_range(0, NUM_REGS - 1));
      if ($urandom_range(0, 1) == 0) it.write_value = 32'($urandom_range(0, 291) * 4 - 64);
    end else if (pick < 85) begin
      it.req_type = REQ_WR_MEM;
    end else if (pick < 91) begin
      it.req_type = REQ_RD_REG;
      if ($urandom_range(0, 5) != 0) it.target_index = 8'($urandom_range(0, NUM_REGS - 1));
    end else if (pick < 97) begin
      it.req_type = REQ_RD_MEM;
    end else begin
      it.req_type = 3'($urandom_range(5, 7));
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch at result %0d: %s got %h want %h", results_checked, what, got, want);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result, status", 32'(got.status), 32'h0);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.read_data !== want.read_data)
      report_mismatch("read_data", got.read_data, want.read_data);
    if (got.next_pc !== want.next_pc)
      report_mismatch("next_pc", 32'(got.next_pc), 32'(want.next_pc));
    if (got.halted !== want.halted)
      report_mismatch("halted", 32'(got.halted), 32'(want.halted));
    if (got.stage_mask !== want.stage_mask)
      report_mismatch("stage_mask", 32'(got.stage_mask), 32'(want.stage_mask));
    if (got.stage_count !== want.stage_count)
      report_mismatch("stage_count", 32'(got.stage_count), 32'(want.stage_count));
    if (got.cycle_total !== want.cycle_total)
      report_mismatch("cycle_total", got.cycle_total, want.cycle_total);
    if (got.instr_number !== want.instr_number)
      report_mismatch("instr_number", got.instr_number, want.instr_number);
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_item);
  end

  // result side: random stalls, bursts, and one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (rx_stall_left > 0) begin
        out_ready <= 1'b0;
        rx_stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!rx_burst && $urandom_range(0, 2) == 0) rx_stall_left = pick_gap();
      end
    end
  end

  task automatic send_request(in_item_t it, bit fixed, out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    predicted = execute_request(it);
    pending_results = {pending_results, (fixed ? want : predicted)};
    requests_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_program_length(logic [PLEN_W-1:0] len);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    prog_len = len;
    settings_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    out_item_t         at_reset;
    out_item_t         none;
    logic [PLEN_W-1:0] plan[6];
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    hold_request  = 1'b0;
    hold_left     = 0;
    rx_stall_left = 0;
    mismatches    = 0;
    cycle_count   = 0;
    pc            = '0;
    cycles_run    = '0;
    instrs_run    = '0;
    prog_len      = '0;
    for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
    none     = '0;
    at_reset = '0;
    at_reset.halted = 1'b1;

    // reset view: program_length 0 halts at pc 0
    add_row(make_req(REQ_RD_REG, 32'h0, 8'd31, 32'h0), 1'b1, at_reset);
    add_row(make_req(REQ_RD_MEM, 32'h0, 8'd255, 32'h0), 1'b1, at_reset);
    add_row(make_req(REQ_UNKNOWN, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF), 1'b1, at_reset);
    add_row(make_req(REQ_RD_REG, 32'h0, 8'd255, 32'h0), 1'b1, at_reset);
    // unsupported opcode: no stages, pc and count still move
    add_row(make_req(REQ_EXEC, 32'hFC000000, 8'h0, 32'h0), 1'b1,
            '{status: ST_BAD_INSTR, read_data: 0, next_pc: 16'd1, halted: 1'b1,
              stage_mask: 5'd0, stage_count: 3'd0, cycle_total: 32'd0,
              instr_number: 32'd1});
    // unsupported funct: IF and ID only
    add_row(make_req(REQ_EXEC, 32'h0000003F, 8'h0, 32'h0), 1'b1,
            '{status: ST_BAD_INSTR, read_data: 0, next_pc: 16'd2, halted: 1'b1,
              stage_mask: STG_IF | STG_ID, stage_count: 3'd2, cycle_total: 32'd2,
              instr_number: 32'd2});
    add_row(make_req(REQ_WR_REG, 32'h0, 8'd0, 32'h7FFFFFFF), 1'b0, none);
    add_row(make_req(REQ_WR_REG, 32'h0, 8'd1, 32'h7FFFFFFF), 1'b0, none);
    add_row(make_req(REQ_WR_REG, 32'h0, 8'd2, 32'h80000000), 1'b0, none);
    add_row(make_req(REQ_WR_REG, 32'h0, 8'd3, 32'hFFFFFFFF), 1'b0, none);
    add_row(make_req(REQ_WR_REG, 32'h0, 8'd40, 32'h55), 1'b0, none);
    add_row(make_req(REQ_EXEC, rtype(5'd1, 5'd1, 5'd4, FN_ADD), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_EXEC, rtype(5'd2, 5'd1, 5'd5, FN_SUB), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_EXEC, rtype(5'd2, 5'd1, 5'd6, FN_SLT), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_EXEC, rtype(5'd3, 5'd1, 5'd0, FN_SLT), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_EXEC, itype(OP_ADDI, 5'd3, 5'd7, 16'h8000), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_WR_MEM, 32'h0, 8'd255, 32'h80000000), 1'b0, none);
    add_row(make_req(REQ_EXEC, itype(OP_SW, 5'd0, 5'd1, 16'd1020), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_EXEC, itype(OP_LW, 5'd0, 5'd8, 16'd1020), 8'd0, 32'd0), 1'b0, none);
    // -1/4 and -3/4 both truncate to zero
    add_row(make_req(REQ_EXEC, itype(OP_LW, 5'd3, 5'd9, 16'hFFFD), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_EXEC, itype(OP_LW, 5'd0, 5'd9, 16'd1024), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_EXEC, itype(OP_SW, 5'd0, 5'd1, 16'hFFFC), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_EXEC, itype(OP_BEQ, 5'd1, 5'd1, 16'hFFFF), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_EXEC, itype(OP_BNE, 5'd1, 5'd2, 16'h7FFF), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_EXEC, itype(OP_BEQ, 5'd1, 5'd2, 16'h0010), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_EXEC, itype(OP_BNE, 5'd1, 5'd1, 16'h0010), 8'd0, 32'd0), 1'b0, none);
    add_row(make_req(REQ_RD_REG, 32'h0, 8'd8, 32'h0), 1'b0, none);
    add_row(make_req(REQ_RD_MEM, 32'h0, 8'd0, 32'h0), 1'b0, none);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_request(rows[i].item, rows[i].fixed, rows[i].want);

    plan = '{15'h7FFF, 15'd24, 15'd0, PLEN_W'($urandom_range(1, 32766)), 15'd1, 15'd300};
    foreach (plan[p]) begin
      write_program_length(plan[p]);
      for (int n = 0; n < PHASE_ITEMS * 5 / 6; n++) begin
        if (n % 60 == 0) begin
          tx_burst = ($urandom_range(0, 3) == 0);
          rx_burst = ($urandom_range(0, 3) == 0);
        end
        if (p == 1 && n == 40) hold_request = 1'b1;
        send_request(random_request(), 1'b0, none);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("%0d requests (%0d instructions) over %0d program_length settings,",
             requests_sent, instrs_run, settings_used);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("mips_integer_subset_executor regression: pass");
    else
      $display("mips_integer_subset_executor regression: fail");
    $finish;
  end

endmodule

// File: mips_integer_subset_executor.f
+incdir+sv
sv/mise_pkg.sv
sv/mise_regfile.sv
sv/mise_dmem.sv
sv/mips_integer_subset_executor.sv
sv/mise_checker.sv
tb/sv/mips_integer_subset_executor_tb.sv
